// ===== rtl/bce_pkg.sv =====
// Package for the binomial coefficient engine: widths, codes and state type.
package bce_pkg;

  localparam int COEF_W = 32;
  localparam int IDX_W  = 6;
  localparam int STAT_W = 2;
  // product of a coefficient and a 6-bit factor
  localparam int ACC_W  = COEF_W + IDX_W;
  localparam int CNT_W  = $clog2(COEF_W);

  localparam logic [IDX_W-1:0] MAX_ORDER = IDX_W'(34);

  localparam logic OP_ROW    = 1'b0;
  localparam logic OP_SINGLE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_K_OVER_N  = 2'd1;
  localparam logic [STAT_W-1:0] ST_N_TOO_BIG = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_DIV
  } state_t;

endpackage

// ===== rtl/binomial_coefficient_engine.sv =====
// Binomial coefficient engine: serial multiply and exact divide over a Pascal row.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------------
//   in      | request   | in_valid, in_ready, in_opcode, in_order, in_index_k
//   out     | result    | out_valid, out_ready, out_coefficient, out_position,
//           |           | out_status, out_last
//
// Each step C(n,j) -> C(n,j+1) runs an issue step, then the bit-serial
// multiply by (n-j), then the restoring divide by (j+1).
// An error request is answered in the cycle after it is accepted.
// Synchronous active-low reset clears control only; no clearing pass.
// A stalled output holds the engine in its issue step; one request at a time.
module binomial_coefficient_engine
  import bce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [IDX_W-1:0]  in_order,
  input  logic [IDX_W-1:0]  in_index_k,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COEF_W-1:0] out_coefficient,
  output logic [IDX_W-1:0]  out_position,
  output logic [STAT_W-1:0] out_status,
  output logic              out_last
);

  state_t state_r, state_nxt;

  logic              op_r, op_nxt;
  logic [IDX_W-1:0]  n_r, n_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [COEF_W-1:0] c_r, c_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [IDX_W-1:0]  m_r, m_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [COEF_W-1:0] out_coef_r, out_coef_nxt;
  logic [IDX_W-1:0]  out_pos_r, out_pos_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;

  logic             slot_free;
  logic             accept;
  logic             err_k;
  logic             err_n;
  logic             emit_now;
  logic             done;
  logic [IDX_W-1:0] divisor;
  logic [IDX_W:0]   trial;
  logic             q_bit;
  logic [IDX_W:0]   rem;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign err_k     = (in_opcode == OP_SINGLE) && (in_index_k > in_order);
  assign err_n     = in_order > MAX_ORDER;

  assign emit_now = (op_r == OP_ROW) || (j_r == k_r);
  assign done     = (op_r == OP_ROW) ? (j_r == n_r) : (j_r == k_r);

  // restoring divide: remainder sits in the top bits of acc_r
  assign divisor = j_r + IDX_W'(1);
  assign trial   = acc_r[ACC_W-1:COEF_W-1];
  assign q_bit   = trial >= {1'b0, divisor};
  assign rem     = q_bit ? (trial - {1'b0, divisor}) : trial;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !err_k && !err_n) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (!emit_now) begin
          state_nxt = S_MUL;
        end else if (slot_free) begin
          state_nxt = done ? S_IDLE : S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_r == CNT_W'(IDX_W - 1)) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(COEF_W - 1)) begin
          state_nxt = S_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    op_nxt        = op_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    acc_nxt       = acc_r;
    m_nxt         = m_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_coef_nxt  = out_coef_r;
    out_pos_nxt   = out_pos_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (err_k || err_n) begin
            out_valid_nxt = 1'b1;
            out_coef_nxt  = '0;
            out_pos_nxt   = '0;
            out_stat_nxt  = err_k ? ST_K_OVER_N : ST_N_TOO_BIG;
            out_last_nxt  = 1'b1;
          end else begin
            op_nxt = in_opcode;
            n_nxt  = in_order;
            k_nxt  = in_index_k;
            j_nxt  = '0;
            c_nxt  = COEF_W'(1);
          end
        end
      end
      S_STEP: begin
        if (emit_now && slot_free) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = c_r;
          out_pos_nxt   = j_r;
          out_stat_nxt  = ST_OK;
          out_last_nxt  = done;
        end
        acc_nxt = '0;
        m_nxt   = n_r - j_r;
        cnt_nxt = '0;
      end
      S_MUL: begin
        // MSB-first shift-add of c_r times (n-j)
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + (m_r[IDX_W-1] ? ACC_W'(c_r) : '0);
        m_nxt   = {m_r[IDX_W-2:0], 1'b0};
        cnt_nxt = (cnt_r == CNT_W'(IDX_W - 1)) ? '0 : cnt_r + CNT_W'(1);
      end
      S_DIV: begin
        acc_nxt = {rem[IDX_W-1:0], acc_r[COEF_W-2:0], q_bit};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(COEF_W - 1)) begin
          c_nxt = acc_nxt[COEF_W-1:0];
          j_nxt = j_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    c_r        <= c_nxt;
    acc_r      <= acc_nxt;
    m_r        <= m_nxt;
    cnt_r      <= cnt_nxt;
    out_coef_r <= out_coef_nxt;
    out_pos_r  <= out_pos_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_position    = out_pos_r;
  assign out_status      = out_stat_r;
  assign out_last        = out_last_r;

  // an error request answers at once with a final result
  a_err_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (err_k || err_n)) |=> (out_valid_r && out_last_r && out_stat_r != ST_OK))
    else $error("error request not answered with a final result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != ST_OK) |-> (out_coef_r == '0 && out_pos_r == '0))
    else $error("error result carries a nonzero coefficient or position");

  // the quotient fits in 32 bits, so the remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (acc_r[ACC_W-1:COEF_W] < divisor))
    else $error("divide remainder reached the divisor");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV) |-> (j_r < n_r && n_r <= MAX_ORDER))
    else $error("recurrence step outside its row");

endmodule
